// ----- rtl/core/ttc_pkg.sv -----
// Shared types and codes for the 16-bit timer/counter with prescaler.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package ttc_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] reg_select;
    logic [7:0] write_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [3:0] irq_vector;
    logic       mode_error;
  } rsp_t;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_POLL  = 2'd3;

  localparam logic [3:0] SEL_CTRL_A = 4'd8;
  localparam logic [3:0] SEL_CTRL_B = 4'd9;
  localparam logic [3:0] SEL_FLAGS  = 4'd10;
  localparam logic [3:0] SEL_MASK   = 4'd11;

  localparam logic [1:0] WIDE_COUNT   = 2'd0;
  localparam logic [1:0] WIDE_CMP_A   = 2'd1;
  localparam logic [1:0] WIDE_CMP_B   = 2'd2;
  localparam logic [1:0] WIDE_CAPTURE = 2'd3;

  localparam logic [3:0] MODE_NORMAL   = 4'd0;
  localparam logic [3:0] MODE_CTC_CMPA = 4'd4;
  localparam logic [3:0] MODE_CTC_ICR  = 4'd12;

  localparam int FLAG_COMPARE_A = 4;
  localparam int FLAG_OVERFLOW  = 2;

  localparam logic [3:0] IRQ_BASE = 4'd11;
  localparam int         PRESCALE_W = 11;

  function automatic logic [PRESCALE_W-1:0] tap_mask(input logic [2:0] cs);
    case (cs)
      3'd1:    tap_mask = 11'd1;
      3'd2:    tap_mask = 11'd8;
      3'd3:    tap_mask = 11'd64;
      3'd4:    tap_mask = 11'd256;
      3'd5:    tap_mask = 11'd1024;
      default: tap_mask = 11'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ttc_core.sv -----
// Timer state and the single-pass step logic for one beat.
// Depends on ttc_pkg for beat types, codes and the prescaler tap table.
`default_nettype none

module ttc_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire ttc_pkg::cmd_t item,
  output ttc_pkg::rsp_t      result
);

  logic [ttc_pkg::PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic [15:0] count_value, count_value_next;
  logic [15:0] compare_a, compare_a_next;
  logic [15:0] compare_b, compare_b_next;
  logic [15:0] capture_value, capture_value_next;
  logic [7:0]  control_a, control_a_next;
  logic [7:0]  control_b, control_b_next;
  logic [7:0]  flag_bits, flag_bits_next;
  logic [7:0]  mask_bits, mask_bits_next;
  logic [7:0]  high_byte_latch, high_byte_latch_next;

  logic [3:0]  mode;
  logic        mode_ok;
  logic [15:0] top_value;
  logic        tap_hit;
  logic [15:0] wide_value;
  logic        latched;
  logic [7:0]  pend;

  always_comb begin
    mode      = {control_b[4:3], control_a[1:0]};
    mode_ok   = (mode == ttc_pkg::MODE_NORMAL) || (mode == ttc_pkg::MODE_CTC_CMPA) ||
                (mode == ttc_pkg::MODE_CTC_ICR);
    top_value = (mode == ttc_pkg::MODE_CTC_CMPA) ? compare_a : capture_value;
    pend      = flag_bits & mask_bits;
    latched   = (item.reg_select[2:1] == ttc_pkg::WIDE_COUNT) ||
                (item.reg_select[2:1] == ttc_pkg::WIDE_CAPTURE);
    case (item.reg_select[2:1])
      ttc_pkg::WIDE_COUNT: wide_value = count_value;
      ttc_pkg::WIDE_CMP_A: wide_value = compare_a;
      ttc_pkg::WIDE_CMP_B: wide_value = compare_b;
      default:             wide_value = capture_value;
    endcase
  end

  always_comb begin
    prescale_count_next  = prescale_count;
    count_value_next     = count_value;
    compare_a_next       = compare_a;
    compare_b_next       = compare_b;
    capture_value_next   = capture_value;
    control_a_next       = control_a;
    control_b_next       = control_b;
    flag_bits_next       = flag_bits;
    mask_bits_next       = mask_bits;
    high_byte_latch_next = high_byte_latch;
    tap_hit              = 1'b0;
    result               = '0;

    case (item.action)
      ttc_pkg::ACT_TICK: begin
        prescale_count_next = prescale_count + 1'b1;
        tap_hit = |((prescale_count ^ prescale_count_next) &
                    ttc_pkg::tap_mask(control_b[2:0]));
        if (tap_hit) begin
          if (!mode_ok) begin
            result.mode_error = 1'b1;
          end else if ((mode != ttc_pkg::MODE_NORMAL) && (count_value == top_value)) begin
            flag_bits_next[ttc_pkg::FLAG_COMPARE_A] = 1'b1;
            count_value_next = '0;
          end else if (count_value == 16'hffff) begin
            flag_bits_next[ttc_pkg::FLAG_OVERFLOW] = 1'b1;
            count_value_next = '0;
          end else begin
            count_value_next = count_value + 16'd1;
          end
        end
      end
      ttc_pkg::ACT_READ: begin
        if (!item.reg_select[3]) begin
          if (!item.reg_select[0]) begin
            result.read_byte = wide_value[7:0];
            if (latched) begin
              high_byte_latch_next = wide_value[15:8];
            end
          end else begin
            result.read_byte = latched ? high_byte_latch : wide_value[15:8];
          end
        end else begin
          case (item.reg_select)
            ttc_pkg::SEL_CTRL_A: result.read_byte = control_a;
            ttc_pkg::SEL_CTRL_B: result.read_byte = control_b;
            ttc_pkg::SEL_FLAGS:  result.read_byte = flag_bits;
            ttc_pkg::SEL_MASK:   result.read_byte = mask_bits;
            default:             result.read_byte = '0;
          endcase
        end
      end
      ttc_pkg::ACT_WRITE: begin
        if (!item.reg_select[3]) begin
          if (item.reg_select[0]) begin
            high_byte_latch_next = item.write_byte;
          end else begin
            case (item.reg_select[2:1])
              ttc_pkg::WIDE_COUNT: count_value_next = {high_byte_latch, item.write_byte};
              ttc_pkg::WIDE_CMP_A: compare_a_next = {high_byte_latch, item.write_byte};
              ttc_pkg::WIDE_CMP_B: compare_b_next = {high_byte_latch, item.write_byte};
              default:             capture_value_next = {high_byte_latch, item.write_byte};
            endcase
          end
        end else begin
          case (item.reg_select)
            ttc_pkg::SEL_CTRL_A: control_a_next = item.write_byte;
            ttc_pkg::SEL_CTRL_B: control_b_next = item.write_byte;
            ttc_pkg::SEL_FLAGS:  flag_bits_next = flag_bits & ~item.write_byte;
            ttc_pkg::SEL_MASK:   mask_bits_next = item.write_byte;
            default:             ;
          endcase
        end
      end
      default: begin
        for (int b = 0; b < 8; b++) begin
          if (pend[b]) begin
            result.irq_vector = ttc_pkg::IRQ_BASE - 4'(b);
            flag_bits_next    = flag_bits & ~(8'd1 << b);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count  <= '0;
      count_value     <= '0;
      compare_a       <= '0;
      compare_b       <= '0;
      capture_value   <= '0;
      control_a       <= '0;
      control_b       <= '0;
      flag_bits       <= '0;
      mask_bits       <= '0;
      high_byte_latch <= '0;
    end else if (fire) begin
      prescale_count  <= prescale_count_next;
      count_value     <= count_value_next;
      compare_a       <= compare_a_next;
      compare_b       <= compare_b_next;
      capture_value   <= capture_value_next;
      control_a       <= control_a_next;
      control_b       <= control_b_next;
      flag_bits       <= flag_bits_next;
      mask_bits       <= mask_bits_next;
      high_byte_latch <= high_byte_latch_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ttc_rsp_reg.sv -----
// Result register: holds one result beat until the consumer takes it.
// Depends on ttc_pkg for the result beat type.
`default_nettype none

module ttc_rsp_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire ttc_pkg::rsp_t data,
  output logic               ready,
  output logic               valid,
  input  wire logic          stall,
  output ttc_pkg::rsp_t      beat
);

  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/timer16_ctc_with_prescaler_top.sv -----
// Top level of the 16-bit timer/counter: command register, step core, result register.
// Depends on ttc_pkg, ttc_core and ttc_rsp_reg.
`default_nettype none

// Takes one command beat per cycle (tick, register read, register write or
// interrupt poll) and returns exactly one result beat for each, in order.
// Throughput is one beat per clock while the result register is not stalled;
// each command passes from the command register through the single-pass
// step logic in ttc_core to the result register. A command is held while the
// result register is full and stalled; cmd_stall follows rsp_stall in the same cycle.
module timer16_ctc_with_prescaler_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire ttc_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ttc_pkg::rsp_t      rsp
);

  logic          hold_valid;
  ttc_pkg::cmd_t hold_item;
  logic          out_ready;
  logic          fire;
  ttc_pkg::rsp_t step_result;

  assign fire      = hold_valid && out_ready;
  assign cmd_stall = hold_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!cmd_stall) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      hold_item <= cmd;
    end
  end

  ttc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (hold_item),
    .result (step_result)
  );

  ttc_rsp_reg u_rsp (
    .clk   (clk),
    .rst   (rst),
    .load  (fire),
    .data  (step_result),
    .ready (out_ready),
    .valid (rsp_valid),
    .stall (rsp_stall),
    .beat  (rsp)
  );

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |=> hold_valid)
    else $error("held command dropped while result register was stalled");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("processed command produced no result beat");

  a_accept_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> hold_valid)
    else $error("accepted command not captured");

  a_rsp_exclusive: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.mode_error) |-> (rsp.read_byte == 8'd0 && rsp.irq_vector == 4'd0))
    else $error("mode error beat carries read or vector data");

endmodule

`default_nettype wire
